/* design/nrvp_pkg.sv */
// ============================================================================
// nrvp_pkg
// Shared widths, register indexes, command and status types, and the
// exponential table generator for the needle rotation velocity profile.
// ============================================================================
`default_nettype none

package nrvp_pkg;

  // Field widths.
  localparam int ANGLE_W  = 20;
  localparam int TARGET_W = 19;
  localparam int EFFORT_W = 17;
  localparam int SCALE_W  = 24;
  localparam int VEL_W    = 18;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 2;

  // Internal datapath widths.
  localparam int DIFF_W  = ANGLE_W + 1;     // signed angular error
  localparam int ABS_W   = ANGLE_W;         // folded error magnitude
  localparam int SQ_W    = 2 * ABS_W - 16;  // square in Q.16
  localparam int ARG_W   = SQ_W + SCALE_W - 16;
  localparam int SPAN_W  = 20;              // 16.0 in Q.16 is 2^20
  localparam int EXP_W   = 17;              // table entry, 65536 is one
  localparam int MAG_W   = 17;

  // Table size and address width.
  localparam int EXP_ENTRIES = 256;
  localparam int EXP_ADDR_W  = $clog2(EXP_ENTRIES);
  localparam int IDX_PROD_W  = SPAN_W + EXP_ADDR_W;

  // Fixed-point constants, radians in units of 2^-16.
  localparam logic signed [DIFF_W-1:0] TWO_PI_Q16 = DIFF_W'(411775);
  localparam logic signed [DIFF_W-1:0] PI_Q16     = DIFF_W'(205887);
  localparam logic [EFFORT_W-1:0]      ONE_Q16    = EFFORT_W'(65536);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION_MODE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_ANGLE    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_STEERING_EFFORT = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_GAUSS_INV_SCALE = CFG_IDX_W'(3);

  localparam logic [SCALE_W-1:0] GAUSS_INV_SCALE_RESET = SCALE_W'(65536);

  // Controller to datapath commands, one step per cycle while not stalled.
  typedef struct packed {
    logic load;      // capture the angle and update the direction
    logic fold;      // error, fold and magnitude
    logic square;    // square of the magnitude
    logic scale;     // times the inverse Gaussian scale
    logic index;     // table index and range check
    logic lookup;    // table read
    logic effort;    // product with the steering effort
    logic out_load;  // write the result register
  } nrvp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic out_full;  // result register holds a transaction not yet taken
  } nrvp_status_t;

  typedef logic [EXP_W-1:0] exp_tab_t [EXP_ENTRIES];

  // Unsigned restoring division, only evaluated while the table is built.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [63:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Samples of exp(-x) for x = 16 * i / EXP_ENTRIES, built as a running
  // product of a Taylor-series ratio.
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t    tab;
    longint      term;
    longint      sum;
    logic [63:0] r31;
    logic [63:0] p;
    term = longint'(1) <<< 40;
    sum  = term;
    for (int k = 1; k <= 14; k++) begin
      term = longint'(udiv64(term * longint'(16), 64'(EXP_ENTRIES * k)));
      if (k[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    r31 = ($unsigned(sum) + 64'd256) >> 9;
    p = 64'd1 << 31;
    tab[0] = EXP_W'((p + (64'd1 << 14)) >> 15);
    for (int i = 1; i < EXP_ENTRIES; i++) begin
      p = (p * r31 + (64'd1 << 30)) >> 31;
      tab[i] = EXP_W'((p + (64'd1 << 14)) >> 15);
    end
    return tab;
  endfunction

endpackage

`default_nettype wire

/* design/nrvp_exp_rom.sv */
// ============================================================================
// nrvp_exp_rom
// Read-only table of the decaying exponential with a registered read port.
// ============================================================================
`default_nettype none

module nrvp_exp_rom (
  input  wire logic                           clk,
  input  wire logic                           rd_en,
  input  wire logic [nrvp_pkg::EXP_ADDR_W-1:0] rd_addr,
  output logic      [nrvp_pkg::EXP_W-1:0]      rd_data
);

  localparam nrvp_pkg::exp_tab_t EXP_TAB = nrvp_pkg::build_exp_tab();

  logic [nrvp_pkg::EXP_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= EXP_TAB[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* design/nrvp_dpath.sv */
// ============================================================================
// nrvp_dpath
// Configuration registers, direction state, arithmetic steps and the
// result register of the velocity profile.
// ============================================================================
`default_nettype none

module nrvp_dpath (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [nrvp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [nrvp_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic signed [nrvp_pkg::ANGLE_W-1:0] in_needle_angle,
  input  wire nrvp_pkg::nrvp_cmd_t                cmd,
  output nrvp_pkg::nrvp_status_t                  status,
  input  wire logic                               out_ready,
  output logic                                    out_valid,
  output logic signed [nrvp_pkg::VEL_W-1:0]       out_rot_velocity,
  output logic                                    out_dir_ccw
);

  // Configuration registers.
  logic                              direction_mode_r;
  logic [nrvp_pkg::TARGET_W-1:0]     target_angle_r;
  logic [nrvp_pkg::EFFORT_W-1:0]     steering_effort_r;
  logic [nrvp_pkg::SCALE_W-1:0]      gauss_inv_scale_r;

  // Direction state and working registers.
  logic                              rotation_dir_r, rotation_dir_nxt;
  logic signed [nrvp_pkg::ANGLE_W-1:0] angle_r;
  logic [nrvp_pkg::ABS_W-1:0]        abs_err_r;
  logic [nrvp_pkg::SQ_W-1:0]         sq_r;
  logic [nrvp_pkg::ARG_W-1:0]        arg_r;
  logic [nrvp_pkg::EXP_ADDR_W-1:0]   idx_r;
  logic                              beyond_r;
  logic                              beyond_d_r;
  logic [2*nrvp_pkg::EFFORT_W-1:0]   prod_r;

  // Result register.
  logic                              out_valid_r;
  logic signed [nrvp_pkg::VEL_W-1:0] out_vel_r;
  logic                              out_dir_r;

  // Combinational step values.
  logic signed [nrvp_pkg::DIFF_W-1:0] diff;
  logic signed [nrvp_pkg::DIFF_W-1:0] folded;
  logic signed [nrvp_pkg::DIFF_W-1:0] abs_full;
  logic [2*nrvp_pkg::ABS_W-1:0]       sq_full;
  logic [nrvp_pkg::SQ_W+nrvp_pkg::SCALE_W-1:0] arg_full;
  logic [nrvp_pkg::IDX_PROD_W-1:0]    idx_full;
  logic [nrvp_pkg::EXP_W-1:0]         exp_val;
  logic [nrvp_pkg::EXP_W-1:0]         exp_eff;
  logic [nrvp_pkg::EFFORT_W-1:0]      alpha;
  logic [2*nrvp_pkg::EFFORT_W-1:0]    rounded;
  logic [nrvp_pkg::MAG_W-1:0]         mag;
  logic signed [nrvp_pkg::VEL_W-1:0]  vel;

  function automatic logic signed [nrvp_pkg::DIFF_W-1:0] DIFF_W_SEXT(
    input logic signed [nrvp_pkg::ANGLE_W-1:0] a
  );
    return {a[nrvp_pkg::ANGLE_W-1], a};
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_mode_r  <= 1'b0;
      target_angle_r    <= '0;
      steering_effort_r <= '0;
      gauss_inv_scale_r <= nrvp_pkg::GAUSS_INV_SCALE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        nrvp_pkg::REG_DIRECTION_MODE:  direction_mode_r  <= cfg_data[0];
        nrvp_pkg::REG_TARGET_ANGLE:    target_angle_r    <= cfg_data[nrvp_pkg::TARGET_W-1:0];
        nrvp_pkg::REG_STEERING_EFFORT: steering_effort_r <= cfg_data[nrvp_pkg::EFFORT_W-1:0];
        nrvp_pkg::REG_GAUSS_INV_SCALE: gauss_inv_scale_r <= cfg_data[nrvp_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Direction governance is applied to the incoming angle. The compare is
  // signed so that negative angles never count as above two pi.
  always_comb begin
    rotation_dir_nxt = rotation_dir_r;
    if (direction_mode_r) begin
      if (DIFF_W_SEXT(in_needle_angle) >= nrvp_pkg::TWO_PI_Q16) begin
        rotation_dir_nxt = 1'b1;
      end else if (in_needle_angle[nrvp_pkg::ANGLE_W-1]) begin
        rotation_dir_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rotation_dir_r <= 1'b0;
    end else if (cmd.load) begin
      rotation_dir_r <= rotation_dir_nxt;
    end
  end

  always_comb begin
    diff = DIFF_W_SEXT(angle_r) - $signed({2'b00, target_angle_r});
    if (diff > nrvp_pkg::PI_Q16) begin
      folded = nrvp_pkg::TWO_PI_Q16 - diff;
    end else begin
      folded = diff;
    end
    abs_full = folded[nrvp_pkg::DIFF_W-1] ? -folded : folded;
    sq_full  = abs_err_r * abs_err_r;
    arg_full = sq_r * gauss_inv_scale_r;
    idx_full = arg_r[nrvp_pkg::SPAN_W-1:0] * nrvp_pkg::IDX_PROD_W'(nrvp_pkg::EXP_ENTRIES);
    exp_eff  = beyond_d_r ? '0 : exp_val;
    alpha    = (steering_effort_r > nrvp_pkg::ONE_Q16) ? nrvp_pkg::ONE_Q16 : steering_effort_r;
    rounded  = (prod_r + (2*nrvp_pkg::EFFORT_W)'(32768)) >> 16;
    mag      = nrvp_pkg::ONE_Q16 - rounded[nrvp_pkg::MAG_W-1:0];
    if (direction_mode_r && rotation_dir_r) begin
      vel = -$signed({1'b0, mag});
    end else begin
      vel = $signed({1'b0, mag});
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      angle_r <= in_needle_angle;
    end
    if (cmd.fold) begin
      abs_err_r <= abs_full[nrvp_pkg::ABS_W-1:0];
    end
    if (cmd.square) begin
      sq_r <= sq_full[2*nrvp_pkg::ABS_W-1:16];
    end
    if (cmd.scale) begin
      arg_r <= arg_full[nrvp_pkg::SQ_W+nrvp_pkg::SCALE_W-1:16];
    end
    if (cmd.index) begin
      idx_r    <= idx_full[nrvp_pkg::SPAN_W +: nrvp_pkg::EXP_ADDR_W];
      beyond_r <= (arg_r[nrvp_pkg::ARG_W-1:nrvp_pkg::SPAN_W] != '0);
    end
    if (cmd.lookup) begin
      beyond_d_r <= beyond_r;
    end
    if (cmd.effort) begin
      prod_r <= alpha * exp_eff;
    end
  end

  nrvp_exp_rom u_exp_rom (
    .clk     (clk),
    .rd_en   (cmd.lookup),
    .rd_addr (idx_r),
    .rd_data (exp_val)
  );

  // Result register: loaded only when empty or being drained.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_vel_r <= vel;
      out_dir_r <= rotation_dir_r;
    end
  end

  assign status.out_full  = out_valid_r && !out_ready;
  assign out_valid        = out_valid_r;
  assign out_rot_velocity = out_vel_r;
  assign out_dir_ccw      = out_dir_r;

endmodule

`default_nettype wire

/* design/nrvp_ctrl.sv */
// ============================================================================
// nrvp_ctrl
// Sequencer that walks one transaction through the datapath steps.
// ============================================================================
`default_nettype none

module nrvp_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  output nrvp_pkg::nrvp_cmd_t         cmd,
  input  wire nrvp_pkg::nrvp_status_t status
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FOLD,
    S_SQUARE,
    S_SCALE,
    S_INDEX,
    S_LOOKUP,
    S_EFFORT,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_FOLD;
        end
      end
      S_FOLD: begin
        cmd.fold  = 1'b1;
        state_nxt = S_SQUARE;
      end
      S_SQUARE: begin
        cmd.square = 1'b1;
        state_nxt  = S_SCALE;
      end
      S_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = S_INDEX;
      end
      S_INDEX: begin
        cmd.index = 1'b1;
        state_nxt = S_LOOKUP;
      end
      S_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_nxt  = S_EFFORT;
      end
      S_EFFORT: begin
        cmd.effort = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        // Hold the finished value until the result register can take it.
        if (!status.out_full) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

/* design/needle_rotation_velocity_profile_top.sv */
// ============================================================================
// needle_rotation_velocity_profile_top
// Turns a needle rotation angle into a normalized, signed rotational velocity.
// ============================================================================
// Usage:
// Each input transaction carries one needle angle (signed, 2^-16 rad). Each
// one produces exactly one output transaction with the velocity (signed
// Q1.16) and the direction state after that sample. Both channels use
// valid/ready; a transaction moves when valid and ready are high together.
// Configuration is written through cfg_we/cfg_index/cfg_data, one register
// per cycle, and should only be changed while no transaction is in flight.
// Each sample passes from idle through seven sequencer steps, one per
// arithmetic stage (fold, square, scale, index, table read, effort, output),
// and a new sample is taken only once the sequencer is back in idle.
// The result sits in an output register, so the next sample is accepted
// while the previous result waits; if the receiver stalls longer, the
// sequencer holds its finished value in the last step and stops accepting.
// Synchronous reset clears the sequencer, the result register, the direction
// state (clockwise) and the configuration registers to their defaults.
// ============================================================================
`default_nettype none

module needle_rotation_velocity_profile_top (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [nrvp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [nrvp_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [nrvp_pkg::ANGLE_W-1:0] in_needle_angle,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [nrvp_pkg::VEL_W-1:0]        out_rot_velocity,
  output logic                                     out_dir_ccw
);

  nrvp_pkg::nrvp_cmd_t    cmd;
  nrvp_pkg::nrvp_status_t status;

  // The sequencer issues one datapath step per cycle unless the output waits.
  nrvp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .status   (status)
  );

  // The datapath owns the configuration, the direction state and the
  // result register.
  nrvp_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_needle_angle  (in_needle_angle),
    .cmd              (cmd),
    .status           (status),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_rot_velocity (out_rot_velocity),
    .out_dir_ccw      (out_dir_ccw)
  );

  // Once a transaction is taken, the input stays closed while it is worked on.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a transaction is in progress");

  // The velocity magnitude never exceeds one.
  a_vel_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_rot_velocity <= 18'sd65536 && out_rot_velocity >= -18'sd65536))
    else $error("velocity outside of plus or minus one");

  // A negative velocity only appears while turning counter-clockwise.
  a_sign_follows_dir: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_dir_ccw) |-> !out_rot_velocity[nrvp_pkg::VEL_W-1])
    else $error("negative velocity with clockwise direction");

endmodule

`default_nettype wire

/* test/nrvp_velocity_checker.sv */
// ============================================================================
// nrvp_velocity_checker
// Watches the configuration port and both channels of the needle rotation
// velocity profile, predicts each result and compares it field by field.
// ============================================================================
`default_nettype none

module nrvp_velocity_checker (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [nrvp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [nrvp_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                                in_valid,
  input  wire logic                                in_ready,
  input  wire logic signed [nrvp_pkg::ANGLE_W-1:0] in_needle_angle,
  input  wire logic                                out_valid,
  input  wire logic                                out_ready,
  input  wire logic signed [nrvp_pkg::VEL_W-1:0]   out_rot_velocity,
  input  wire logic                                out_dir_ccw,
  output int                                       fail_count,
  output int                                       pending
);

  import nrvp_pkg::*;

  // 16.0 in Q.16: exponent arguments at or above this read as zero.
  localparam longint EXP_ARG_SPAN = 64'd1 << 20;

  typedef struct {
    logic signed [VEL_W-1:0] vel;
    logic                    ccw;
  } velocity_t;

  logic [EXP_W-1:0]    exp_lut [EXP_ENTRIES];
  logic                mode_r;
  logic [TARGET_W-1:0] target_r;
  logic [EFFORT_W-1:0] effort_r;
  logic [SCALE_W-1:0]  scale_r;
  logic                dir_r;
  velocity_t           velocity_expect_q [$];
  velocity_t           due;
  int                  errors;

  // Samples of exp(-16 i / N) as a running product of a Taylor-series ratio.
  function automatic void build_exp_lut();
    longint      term;
    longint      acc;
    logic [63:0] ratio;
    logic [63:0] run;
    term = longint'(1) << 40;
    acc  = term;
    for (int k = 1; k <= 14; k++) begin
      term = (term * 16) / longint'(EXP_ENTRIES * k);
      acc  = (k % 2 == 1) ? acc - term : acc + term;
    end
    ratio = acc;
    ratio = (ratio + 64'd256) >> 9;
    run   = 64'd1 << 31;
    exp_lut[0] = EXP_W'((run + (64'd1 << 14)) >> 15);
    for (int i = 1; i < EXP_ENTRIES; i++) begin
      run = (run * ratio + (64'd1 << 30)) >> 31;
      exp_lut[i] = EXP_W'((run + (64'd1 << 14)) >> 15);
    end
  endfunction

  // Advances the direction state and returns the velocity for one angle.
  function automatic velocity_t predict_velocity(input logic signed [ANGLE_W-1:0] angle);
    velocity_t   res;
    longint      a;
    longint      err;
    logic [63:0] err_abs;
    logic [63:0] sq;
    logic [63:0] arg;
    logic [63:0] smp;
    logic [63:0] alpha;
    logic [63:0] mag;
    a = angle;
    if (mode_r) begin
      if (a >= TWO_PI_Q16) begin
        dir_r = 1'b1;
      end else if (a < 0) begin
        dir_r = 1'b0;
      end
    end
    err = a - longint'(target_r);
    if (err > PI_Q16) begin
      err = TWO_PI_Q16 - err;
    end
    err_abs = (err < 0) ? -err : err;
    sq  = (err_abs * err_abs) >> 16;
    arg = (sq * 64'(scale_r)) >> 16;
    if (arg >= EXP_ARG_SPAN) begin
      smp = 0;
    end else begin
      smp = exp_lut[(arg * EXP_ENTRIES) >> 20];
    end
    alpha = (effort_r > ONE_Q16) ? 64'(ONE_Q16) : 64'(effort_r);
    mag   = 64'(ONE_Q16) - ((alpha * smp + 64'd32768) >> 16);
    res.vel = (mode_r && dir_r) ? VEL_W'(-mag) : VEL_W'(mag);
    res.ccw = dir_r;
    return res;
  endfunction

  initial begin
    errors = 0;
    build_exp_lut();
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      velocity_expect_q.delete();
      mode_r   = 1'b0;
      target_r = '0;
      effort_r = '0;
      scale_r  = GAUSS_INV_SCALE_RESET;
      dir_r    = 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DIRECTION_MODE:  mode_r   = cfg_data[0];
          REG_TARGET_ANGLE:    target_r = cfg_data[TARGET_W-1:0];
          REG_STEERING_EFFORT: effort_r = cfg_data[EFFORT_W-1:0];
          REG_GAUSS_INV_SCALE: scale_r  = cfg_data[SCALE_W-1:0];
          default: ;
        endcase
      end
      // A result can never belong to an angle taken at the same edge, so the
      // comparison runs before the new prediction is queued.
      if (out_valid && out_ready) begin
        if (velocity_expect_q.size() == 0) begin
          errors++;
          $error("rot_velocity: no transaction expected, actual %0d", out_rot_velocity);
        end else begin
          due = velocity_expect_q.pop_front();
          if (out_rot_velocity !== due.vel) begin
            errors++;
            $error("rot_velocity: expected %0d, actual %0d", due.vel, out_rot_velocity);
          end
          if (out_dir_ccw !== due.ccw) begin
            errors++;
            $error("dir_ccw: expected %0d, actual %0d", due.ccw, out_dir_ccw);
          end
        end
      end
      if (in_valid && in_ready) begin
        velocity_expect_q.push_back(predict_velocity(in_needle_angle));
      end
    end
    fail_count <= errors;
    pending    <= velocity_expect_q.size();
  end

endmodule

`default_nettype wire

/* test/needle_rotation_velocity_profile_top_tb.sv */
// ============================================================================
// needle_rotation_velocity_profile_top_tb
// Drives needle angles and register settings into the velocity profile block
// and lets a side-by-side checker predict and compare every result.
// ============================================================================
`default_nettype none

module needle_rotation_velocity_profile_top_tb;

  import nrvp_pkg::*;

  localparam int CLK_HALF      = 10;
  localparam int RESET_CYCLES  = 11;
  // Generous bound on the whole run; the slowest legal run is far shorter.
  localparam int CYCLE_LIMIT   = 400000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 20;
  localparam int PHASES        = 3;
  localparam int BLOCKS        = 4;
  localparam int BLOCK_ITEMS   = 67;

  logic                        clk;
  logic                        rst_n;
  logic                        cfg_we;
  logic [CFG_IDX_W-1:0]        cfg_index;
  logic [CFG_DATA_W-1:0]       cfg_data;
  logic                        in_valid;
  logic                        in_ready;
  logic signed [ANGLE_W-1:0]   in_needle_angle;
  logic                        out_valid;
  logic                        out_ready;
  logic signed [VEL_W-1:0]     out_rot_velocity;
  logic                        out_dir_ccw;

  int                          chk_fail;
  int                          chk_pending;
  int                          send_idle_pct;
  int                          recv_idle_pct;
  int                          hold_request;
  int                          hold_seen;
  int                          hold_left;
  int                          cycle_cnt;
  logic [TARGET_W-1:0]         cur_target;

  initial clk = 1'b0;
  always #CLK_HALF clk = ~clk;

  needle_rotation_velocity_profile_top i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_needle_angle  (in_needle_angle),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_rot_velocity (out_rot_velocity),
    .out_dir_ccw      (out_dir_ccw)
  );

  nrvp_velocity_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_needle_angle  (in_needle_angle),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_rot_velocity (out_rot_velocity),
    .out_dir_ccw      (out_dir_ccw),
    .fail_count       (chk_fail),
    .pending          (chk_pending)
  );

  // Receiver. It drops ready at random according to recv_idle_pct. Each time
  // the stimulus bumps hold_request, it holds ready low for a long stretch,
  // counted here, so that the block fills up and backs up its input.
  always @(posedge clk) begin
    if (hold_request != hold_seen) begin
      hold_seen = hold_request;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Offers one angle transaction and returns at the edge that accepts it.
  // Valid stays high on return, so a back-to-back transaction keeps it up
  // without a second assignment in the same time step. While idle, the angle
  // bus carries junk to show that the block only looks at it under valid.
  task automatic push_angle(input logic signed [ANGLE_W-1:0] angle);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid        <= 1'b0;
      in_needle_angle <= ANGLE_W'($urandom);
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_needle_angle <= angle;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
  endtask

  // Stops offering and waits until every expected result has arrived. The
  // first edge lets the checker's count catch up with a transaction that was
  // accepted at the edge this task was called on.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (chk_pending != 0) begin
      @(posedge clk);
    end
  endtask

  // Rewrites all four registers once the block has gone quiet.
  task automatic program_regs(input logic mode, input logic [TARGET_W-1:0] target,
                              input logic [EFFORT_W-1:0] effort,
                              input logic [SCALE_W-1:0] scale);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_DIRECTION_MODE;
    cfg_data  <= CFG_DATA_W'(mode);
    @(posedge clk);
    cfg_index <= REG_TARGET_ANGLE;
    cfg_data  <= CFG_DATA_W'(target);
    @(posedge clk);
    cfg_index <= REG_STEERING_EFFORT;
    cfg_data  <= CFG_DATA_W'(effort);
    @(posedge clk);
    cfg_index <= REG_GAUSS_INV_SCALE;
    cfg_data  <= CFG_DATA_W'(scale);
    @(posedge clk);
    cfg_we     <= 1'b0;
    cur_target  = target;
  endtask

  // Angles: a mix of the full signed range, values close to the target where
  // the Gaussian dip is visible, values around zero and two pi where the
  // direction flips, and plain in-range angles.
  function automatic logic signed [ANGLE_W-1:0] pick_angle();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2: v = $urandom;
      3, 4, 5: v = int'(cur_target) + int'($urandom_range(0, 40000)) - 20000;
      6:       v = int'($urandom_range(0, 3000)) - 1500;
      7:       v = 411775 + int'($urandom_range(0, 3000)) - 1500;
      default: v = $urandom_range(0, 411774);
    endcase
    return ANGLE_W'(v);
  endfunction

  function automatic logic [TARGET_W-1:0] pick_target();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return TARGET_W'(411774);
      2:       return '1;
      default: return TARGET_W'($urandom_range(0, 411774));
    endcase
  endfunction

  // Efforts above one are legal register values and saturate in the block.
  function automatic logic [EFFORT_W-1:0] pick_effort();
    case ($urandom_range(0, 6))
      0:       return '0;
      1:       return EFFORT_W'(65536);
      2:       return '1;
      3:       return EFFORT_W'($urandom_range(65537, 131071));
      default: return EFFORT_W'($urandom_range(0, 65536));
    endcase
  endfunction

  // Most scales put the table's range across the angle span; the rest are
  // the extremes and the full register range.
  function automatic logic [SCALE_W-1:0] pick_scale();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return SCALE_W'(1);
      2:       return '1;
      3:       return SCALE_W'($urandom_range(1, 16777215));
      default: return SCALE_W'($urandom_range(2000, 400000));
    endcase
  endfunction

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    in_valid        = 1'b0;
    in_needle_angle = '0;
    out_ready       = 1'b0;
    send_idle_pct   = 0;
    recv_idle_pct   = 0;
    hold_request    = 0;
    hold_seen       = 0;
    hold_left       = 0;
    cycle_cnt       = 0;
    cur_target      = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Register defaults straight out of reset: zero effort gives full speed.
    push_angle(ANGLE_W'(0));
    push_angle(ANGLE_W'(-1));

    // Bidirectional with full effort: zero error, the fold at pi, angles at
    // and above two pi that turn the direction counter-clockwise, negative
    // angles that turn it back, and both ends of the angle range.
    program_regs(1'b1, '0, EFFORT_W'(65536), SCALE_W'(65536));
    push_angle(ANGLE_W'(0));
    push_angle(ANGLE_W'(411775));
    push_angle(ANGLE_W'(524287));
    push_angle(ANGLE_W'(205887));
    push_angle(ANGLE_W'(205888));
    push_angle(ANGLE_W'(411774));
    push_angle(ANGLE_W'(-1));
    push_angle(ANGLE_W'(-524288));
    push_angle(ANGLE_W'(100000));
    push_angle(ANGLE_W'(1));

    // Unidirectional with an effort above one, which saturates.
    program_regs(1'b0, TARGET_W'(411774), '1, SCALE_W'(65536));
    push_angle(ANGLE_W'(411774));
    push_angle(ANGLE_W'(0));
    push_angle(ANGLE_W'(205887));

    // Zero scale: the exponential is always one, so the speed is 1 - alpha.
    program_regs(1'b1, TARGET_W'(100000), EFFORT_W'(32768), '0);
    push_angle(ANGLE_W'(411775));
    push_angle(ANGLE_W'(12345));
    push_angle(ANGLE_W'(-5));

    // Target beyond two pi used as given, largest scale, and an error far
    // below minus pi that is left unfolded.
    program_regs(1'b1, '1, EFFORT_W'(65536), '1);
    push_angle(ANGLE_W'(-524288));
    push_angle(ANGLE_W'(524287));
    push_angle(ANGLE_W'(524286));

    // Smallest nonzero scale.
    program_regs(1'b0, '0, EFFORT_W'(65536), SCALE_W'(1));
    push_angle(ANGLE_W'(205887));
    push_angle(ANGLE_W'(300000));

    // Random part in three idling phases: sender idle 24 and receiver idle
    // 49 percent of cycles, then swapped, then no idling at all. Each phase
    // runs several register settings.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 24;
          recv_idle_pct = 49;
        end
        1: begin
          send_idle_pct = 49;
          recv_idle_pct = 24;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int blk = 0; blk < BLOCKS; blk++) begin
        program_regs(1'($urandom), pick_target(), pick_effort(), pick_scale());
        // Long receiver hold-off while angles keep coming.
        if (phase == 0 && blk == 1) begin
          hold_request <= hold_request + 1;
        end
        for (int n = 0; n < BLOCK_ITEMS; n++) begin
          // Sender pauses mid-stream until the pipeline has fully drained.
          if (phase == 1 && blk == 2 && n == BLOCK_ITEMS / 2) begin
            wait_idle();
          end
          push_angle(pick_angle());
        end
      end
    end

    // Drain, then give the block a few more cycles to show any stray result.
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (chk_fail == 0 && chk_pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
